// ----- rtl/core/escape_time_fractal_pixel_unit_defines.svh -----
// Assertion macros used by the checker file of the fractal pixel unit
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define EFP_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efp check failed");

// next-cycle implication, masked during reset
`define EFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("efp check failed");

// what must hold in the cycle after reset
`define EFP_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("efp reset check failed");

`endif

// ----- rtl/core/efp_pkg.sv -----
// Types, constants and helper functions of the escape-time fractal pixel unit
package efp_pkg;

   localparam int MAX_GRID   = 1024;
   localparam int GRID_W     = $clog2(MAX_GRID + 1);
   localparam int FRAC_BITS  = 26;
   localparam int COORD_W    = 32;
   localparam int STEP_W     = 31;
   localparam int ITER_W     = 16;
   localparam int PIXEL_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int OFFS_W     = STEP_W + GRID_W;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SAT_IN_W   = PROD_W + 2;

   // with a very wide fraction no 32-bit z can reach |z|^2 > 4
   localparam bit ESC_NEVER = (2 * FRAC_BITS + 2 >= PROD_W);
   localparam logic [PROD_W-1:0] ESC_LIMIT =
      ESC_NEVER ? '0 : (PROD_W'(4) << (ESC_NEVER ? 0 : 2 * FRAC_BITS));

   localparam logic [PIXEL_W-1:0] PIXEL_INSIDE  = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_ESCAPED = 8'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_X_ORIGIN   = 3'd1,
      CSR_Y_ORIGIN   = 3'd2,
      CSR_X_STEP     = 3'd3,
      CSR_Y_STEP     = 3'd4,
      CSR_ITER_LIMIT = 3'd5,
      CSR_JULIA_RE   = 3'd6,
      CSR_JULIA_IM   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic                       mode;
      logic signed [COORD_W-1:0]  x_origin;
      logic signed [COORD_W-1:0]  y_origin;
      logic        [STEP_W-1:0]   x_step;
      logic        [STEP_W-1:0]   y_step;
      logic        [ITER_W-1:0]   iter_limit;
      logic signed [COORD_W-1:0]  julia_re;
      logic signed [COORD_W-1:0]  julia_im;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:       1'b0,
      x_origin:   -32'sd134217728,
      y_origin:   -32'sd134217728,
      x_step:     31'd262144,
      y_step:     31'd262144,
      iter_limit: 16'd100,
      julia_re:   32'sd0,
      julia_im:   32'sd0
   };

   typedef struct packed {
      logic capture;      // take row/col of an accepted item
      logic load_offset;  // register step * index
      logic load_point;   // form c, seed z and the constant
      logic mul;          // register the three products
      logic update;       // z <= z*z + k
      logic mark_out;     // point escaped
      logic emit;         // load the result register
   } efp_cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic escaped;
      logic last_iter;
   } efp_status_type;

   // clamp to the signed coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-COORD_W:0] top;
      top = v[SAT_IN_W-1:COORD_W-1];
      if ((top == '0) || (top == '1))
         return v[COORD_W-1:0];
      else if (v[SAT_IN_W-1])
         return {1'b1, {(COORD_W-1){1'b0}}};
      else
         return {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

endpackage

// ----- rtl/core/efp_interfaces.sv -----
// Channel interfaces of the fractal pixel unit: request, result and register write
interface efp_req_if;
   logic                           valid;
   logic                           ready;
   logic [efp_pkg::GRID_W-1:0]     row;
   logic [efp_pkg::GRID_W-1:0]     col;
   modport source (output valid, row, col, input ready);
   modport sink   (input valid, row, col, output ready);
endinterface

interface efp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [efp_pkg::PIXEL_W-1:0]    pixel;
   logic [efp_pkg::GRID_W-1:0]     out_row;
   logic [efp_pkg::GRID_W-1:0]     out_col;
   modport source (output valid, pixel, out_row, out_col, input ready);
   modport sink   (input valid, pixel, out_row, out_col, output ready);
endinterface

interface efp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [efp_pkg::CSR_IDX_W-1:0]    index;
   logic [efp_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/efp_csr.sv -----
// Configuration register file of the fractal pixel unit
module efp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_valid,
   input  logic [efp_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0]  wr_data,
   output logic                            wr_ready,
   output efp_pkg::cfg_type                cfg
);

   efp_pkg::cfg_type cfg_ff, cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (efp_pkg::csr_idx_type'(wr_index))
            efp_pkg::CSR_MODE:       cfg_in.mode       = wr_data[0];
            efp_pkg::CSR_X_ORIGIN:   cfg_in.x_origin   = wr_data[efp_pkg::COORD_W-1:0];
            efp_pkg::CSR_Y_ORIGIN:   cfg_in.y_origin   = wr_data[efp_pkg::COORD_W-1:0];
            efp_pkg::CSR_X_STEP:     cfg_in.x_step     = wr_data[efp_pkg::STEP_W-1:0];
            efp_pkg::CSR_Y_STEP:     cfg_in.y_step     = wr_data[efp_pkg::STEP_W-1:0];
            efp_pkg::CSR_ITER_LIMIT: cfg_in.iter_limit = wr_data[efp_pkg::ITER_W-1:0];
            efp_pkg::CSR_JULIA_RE:   cfg_in.julia_re   = wr_data[efp_pkg::COORD_W-1:0];
            efp_pkg::CSR_JULIA_IM:   cfg_in.julia_im   = wr_data[efp_pkg::COORD_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= efp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/efp_datapath.sv -----
// Datapath of the fractal pixel unit: point setup, complex squaring, escape test
module efp_datapath (
   input  logic                          clock,
   input  efp_pkg::cfg_type              cfg,
   input  efp_pkg::efp_cmd_type          cmd,
   input  logic [efp_pkg::GRID_W-1:0]    req_row,
   input  logic [efp_pkg::GRID_W-1:0]    req_col,
   output efp_pkg::efp_status_type       status,
   output logic [efp_pkg::PIXEL_W-1:0]   pixel,
   output logic [efp_pkg::GRID_W-1:0]    out_row,
   output logic [efp_pkg::GRID_W-1:0]    out_col
);

   localparam int CW = efp_pkg::COORD_W;
   localparam int PW = efp_pkg::PROD_W;
   localparam int SW = efp_pkg::SAT_IN_W;
   localparam int OW = efp_pkg::OFFS_W;

   logic [efp_pkg::GRID_W-1:0]  row_ff, col_ff;
   logic [OW-1:0]               offs_re_ff, offs_im_ff;
   logic signed [CW-1:0]        zr_ff, zi_ff, kr_ff, ki_ff;
   logic signed [PW-1:0]        rr_ff, ii_ff, ri_ff;
   logic [efp_pkg::ITER_W-1:0]  iter_ff;
   logic                        inside_ff;
   logic [efp_pkg::PIXEL_W-1:0] pixel_ff;
   logic [efp_pkg::GRID_W-1:0]  out_row_ff, out_col_ff;

   logic [OW-1:0]        offs_re_in, offs_im_in;
   logic signed [SW-1:0] pr_sum, pi_sum;
   logic signed [CW-1:0] pr, pi;
   logic signed [PW-1:0] rr_in, ii_in, ri_in;
   logic signed [PW-1:0] diff, re_sh, im_sh;
   logic signed [SW-1:0] re_sum, im_sum;
   logic [PW-1:0]        mag;

   assign offs_re_in = OW'(cfg.x_step) * OW'(row_ff);
   assign offs_im_in = OW'(cfg.y_step) * OW'(col_ff);

   assign pr_sum = {{(SW-CW){cfg.x_origin[CW-1]}}, cfg.x_origin}
                 + {{(SW-OW){1'b0}}, offs_re_ff};
   assign pi_sum = {{(SW-CW){cfg.y_origin[CW-1]}}, cfg.y_origin}
                 + {{(SW-OW){1'b0}}, offs_im_ff};
   assign pr = efp_pkg::sat_coord(pr_sum);
   assign pi = efp_pkg::sat_coord(pi_sum);

   assign rr_in = PW'(zr_ff) * PW'(zr_ff);
   assign ii_in = PW'(zi_ff) * PW'(zi_ff);
   assign ri_in = PW'(zr_ff) * PW'(zi_ff);

   // both squares are nonnegative and at most 2^62, so neither line wraps
   assign diff   = rr_ff - ii_ff;
   assign re_sh  = diff >>> efp_pkg::FRAC_BITS;
   assign im_sh  = ri_ff >>> (efp_pkg::FRAC_BITS - 1);
   assign re_sum = {{(SW-PW){re_sh[PW-1]}}, re_sh} + {{(SW-CW){kr_ff[CW-1]}}, kr_ff};
   assign im_sum = {{(SW-PW){im_sh[PW-1]}}, im_sh} + {{(SW-CW){ki_ff[CW-1]}}, ki_ff};
   assign mag    = $unsigned(rr_ff) + $unsigned(ii_ff);

   assign status.limit_zero = (cfg.iter_limit == '0);
   assign status.escaped    = !efp_pkg::ESC_NEVER && (mag > efp_pkg::ESC_LIMIT);
   assign status.last_iter  = (({1'b0, iter_ff} + 1'b1) == {1'b0, cfg.iter_limit});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (cmd.load_offset) begin
         offs_re_ff <= offs_re_in;
         offs_im_ff <= offs_im_in;
      end
      if (cmd.load_point) begin
         zr_ff     <= pr;
         zi_ff     <= pi;
         kr_ff     <= cfg.mode ? cfg.julia_re : pr;
         ki_ff     <= cfg.mode ? cfg.julia_im : pi;
         iter_ff   <= '0;
         inside_ff <= 1'b1;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.update) begin
         zr_ff   <= efp_pkg::sat_coord(re_sum);
         zi_ff   <= efp_pkg::sat_coord(im_sum);
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.mark_out) begin
         inside_ff <= 1'b0;
      end
      if (cmd.emit) begin
         pixel_ff   <= inside_ff ? efp_pkg::PIXEL_INSIDE : efp_pkg::PIXEL_ESCAPED;
         out_row_ff <= row_ff;
         out_col_ff <= col_ff;
      end
   end

   assign pixel   = pixel_ff;
   assign out_row = out_row_ff;
   assign out_col = out_col_ff;

endmodule

// ----- rtl/core/efp_ctrl.sv -----
// Sequencer of the fractal pixel unit: handshakes and iteration control
module efp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  efp_pkg::efp_status_type  status,
   output efp_pkg::efp_cmd_type     cmd
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_OFFS = 6'b000010,
      S_LOAD = 6'b000100,
      S_MUL  = 6'b001000,
      S_CHK  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_OFFS;
            end
         end
         S_OFFS: begin
            cmd.load_offset = 1'b1;
            state_in        = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_point = 1'b1;
            state_in       = status.limit_zero ? S_DONE : S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (status.escaped) begin
               cmd.mark_out = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.update = 1'b1;
               state_in   = status.last_iter ? S_DONE : S_MUL;
            end
         end
         S_DONE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/escape_time_fractal_pixel_unit.sv -----
// After an accept: offsets registered, point loaded, t escape tests run (t <= iter_limit), result
// register loaded. Each test runs S_MUL for the three 32x32 products, then S_CHK for test and z
// update. A new item is taken only after the last one is emitted; a waiting result lets one more
// item in, then holds the sequencer in its last state until the result register frees up.
// Reset (synchronous, active high) returns the sequencer to idle, drops the result valid
// and loads every configuration register with its default value.
module escape_time_fractal_pixel_unit (
   input  logic       clock,
   input  logic       reset,
   efp_req_if.sink    req_if,
   efp_rsp_if.source  rsp_if,
   efp_csr_if.sink    csr_if
);

   efp_pkg::cfg_type        cfg;
   efp_pkg::efp_cmd_type    cmd;
   efp_pkg::efp_status_type status;

   efp_csr u_efp_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .wr_ready (csr_if.ready),
      .cfg      (cfg)
   );

   efp_ctrl u_efp_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   efp_datapath u_efp_datapath (
      .clock   (clock),
      .cfg     (cfg),
      .cmd     (cmd),
      .req_row (req_if.row),
      .req_col (req_if.col),
      .status  (status),
      .pixel   (rsp_if.pixel),
      .out_row (rsp_if.out_row),
      .out_col (rsp_if.out_col)
   );

endmodule

// ----- rtl/core/efp_checker.sv -----
// Port-level checker of the fractal pixel unit and its bind to the top level
`include "escape_time_fractal_pixel_unit_defines.svh"

module efp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [efp_pkg::PIXEL_W-1:0]  rsp_pixel
);

   // one item at a time: the unit is busy right after taking an item
   `EFP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   `EFP_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `EFP_ASSERT_HOLDS(a_pixel_code, clock, reset, rsp_valid, (rsp_pixel == efp_pkg::PIXEL_INSIDE) || (rsp_pixel == efp_pkg::PIXEL_ESCAPED))

   `EFP_ASSERT_AFTER_RESET(a_no_rsp_after_reset, clock, reset, !rsp_valid)

endmodule

bind escape_time_fractal_pixel_unit efp_checker u_efp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_pixel (rsp_if.pixel)
);

// ----- verif/tb_top.sv -----
// Self-checking bench for the escape-time fractal pixel unit: directed corners, then random settings
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import efp_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [GRID_W-1:0]  row;
      logic [GRID_W-1:0]  col;
   } pixel_result_t;

   typedef enum bit {DIR_POINT, DIR_WRITE} dir_kind_e;

   typedef struct packed {
      dir_kind_e          kind;
      csr_idx_type        reg_idx;
      logic [31:0]        data;
      logic [GRID_W-1:0]  row;
      logic [GRID_W-1:0]  col;
      bit                 typed;   // pixel below is known by inspection
      logic [PIXEL_W-1:0] pixel;
   } dir_row_t;

   localparam int N_DIRECTED = 49;
   localparam int N_PHASES   = 16;
   localparam int PHASE_PTS  = 125;

   // default settings: origin (-2,-2), 1/256 per step, 100 updates
   localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd0,    1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd512,  11'd512,  1'b1, PIXEL_INSIDE},
      // (-2,0) lands on (2,0), a fixed point with |z|^2 == 4
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd512,  1'b1, PIXEL_INSIDE},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd1024, 11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd2047, 11'd2047, 1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd2047, 11'd0,    1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd2047, 1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd700,  11'd600,  1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd400,  11'd560,  1'b0, PIXEL_ESCAPED},
      // (1.5,0): escapes only if a test follows the first update
      '{DIR_WRITE, CSR_ITER_LIMIT, 32'd1,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd896,  11'd512,  1'b1, PIXEL_INSIDE},
      '{DIR_WRITE, CSR_ITER_LIMIT, 32'd2,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd896,  11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_ITER_LIMIT, 32'd0,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd0,    1'b1, PIXEL_INSIDE},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd2047, 11'd2047, 1'b1, PIXEL_INSIDE},
      // coordinate sums that saturate high, and coordinates at the low end of the range
      '{DIR_WRITE, CSR_ITER_LIMIT, 32'd16,       11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_X_STEP,     32'h7FFFFFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_X_ORIGIN,   32'h7FFFFFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd2047, 11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_X_ORIGIN,   32'h80000000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_X_STEP,     32'h0,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_Y_ORIGIN,   32'h80000000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_Y_STEP,     32'h7FFFFFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd0,    1'b1, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd5,    11'd2047, 1'b1, PIXEL_ESCAPED},
      // Julia mode, constant zero first
      '{DIR_WRITE, CSR_X_ORIGIN,   32'hF8000000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_X_STEP,     32'h00040000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_Y_ORIGIN,   32'hF8000000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_Y_STEP,     32'h00040000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_MODE,       32'h1,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd640,  11'd512,  1'b1, PIXEL_INSIDE},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd896,  11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_RE,   32'h7FFFFFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd512,  11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_RE,   32'h80000000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_IM,   32'h7FFFFFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd512,  11'd512,  1'b1, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_RE,   32'hFCCCCCCD, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_IM,   32'h00A00000, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd600,  11'd540,  1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd512,  11'd512,  1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd560,  11'd470,  1'b0, PIXEL_ESCAPED},
      // full iteration budget on the fixed point at (-2,0)
      '{DIR_WRITE, CSR_MODE,       32'h0,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_RE,   32'h0,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_JULIA_IM,   32'h0,        11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_WRITE, CSR_ITER_LIMIT, 32'h0000FFFF, 11'd0,    11'd0,    1'b0, PIXEL_ESCAPED},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd512,  1'b1, PIXEL_INSIDE},
      '{DIR_POINT, CSR_MODE,       32'h0,        11'd0,    11'd0,    1'b1, PIXEL_ESCAPED}
   };

   logic clock;
   logic reset;

   efp_req_if req_if ();
   efp_rsp_if rsp_if ();
   efp_csr_if csr_if ();

   escape_time_fractal_pixel_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   cfg_type       cfg_model = CFG_RESET;
   pixel_result_t pixels_due[$];
   int            mismatches = 0;
   int            points_seen = 0;
   int            inside_seen = 0;
   int            escaped_seen = 0;
   int            writes_seen = 0;
   int            req_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            hold_cycles = 0;
   bit            point_typed = 1'b0;
   logic [PIXEL_W-1:0] point_typed_pixel = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("escape_time_fractal_pixel_unit test failed");
      $finish;
   end

   function automatic longint clamp_s32(longint v);
      if (v > 64'sd2147483647)
         return 64'sd2147483647;
      if (v < -64'sd2147483648)
         return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [PIXEL_W-1:0] escape_time_pixel(cfg_type c,
                                                           logic [GRID_W-1:0] r,
                                                           logic [GRID_W-1:0] q);
      longint pr, pi, kr, ki, zr, zi, rr, ii, ri;
      longint unsigned mag, bound;
      bit never;
      never = (2 * FRAC_BITS + 2 >= 64);
      bound = never ? 64'd0 : (64'd4 << (2 * FRAC_BITS));
      pr = clamp_s32(longint'($signed(c.x_origin)) +
                     longint'({1'b0, c.x_step}) * longint'({1'b0, r}));
      pi = clamp_s32(longint'($signed(c.y_origin)) +
                     longint'({1'b0, c.y_step}) * longint'({1'b0, q}));
      if (c.mode) begin
         kr = longint'($signed(c.julia_re));
         ki = longint'($signed(c.julia_im));
      end else begin
         kr = pr;
         ki = pi;
      end
      zr = pr;
      zi = pi;
      for (int n = 0; n < int'(c.iter_limit); n++) begin
         mag = $unsigned(zr * zr) + $unsigned(zi * zi);
         if (!never && mag > bound)
            return PIXEL_ESCAPED;
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         zr = clamp_s32(((rr - ii) >>> FRAC_BITS) + kr);
         zi = clamp_s32((ri >>> (FRAC_BITS - 1)) + ki);
      end
      return PIXEL_INSIDE;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result check first, then register writes, then new points
   always @(posedge clock) begin
      pixel_result_t got, want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.pixel, rsp_if.out_row, rsp_if.out_col};
            if (pixels_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, got pixel %0d row %0d col %0d",
                        $time, got.pixel, got.row, got.col);
               mismatches++;
            end else begin
               want = pixels_due.pop_front();
               compare_field("pixel", 32'(want.pixel), 32'(got.pixel));
               compare_field("out_row", 32'(want.row), 32'(got.row));
               compare_field("out_col", 32'(want.col), 32'(got.col));
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            writes_seen++;
            case (csr_idx_type'(csr_if.index))
               CSR_MODE:       cfg_model.mode       = csr_if.data[0];
               CSR_X_ORIGIN:   cfg_model.x_origin   = csr_if.data;
               CSR_Y_ORIGIN:   cfg_model.y_origin   = csr_if.data;
               CSR_X_STEP:     cfg_model.x_step     = csr_if.data[STEP_W-1:0];
               CSR_Y_STEP:     cfg_model.y_step     = csr_if.data[STEP_W-1:0];
               CSR_ITER_LIMIT: cfg_model.iter_limit = csr_if.data[ITER_W-1:0];
               CSR_JULIA_RE:   cfg_model.julia_re   = csr_if.data;
               CSR_JULIA_IM:   cfg_model.julia_im   = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            want.row = req_if.row;
            want.col = req_if.col;
            want.pixel = point_typed ? point_typed_pixel
                                     : escape_time_pixel(cfg_model, req_if.row, req_if.col);
            if (want.pixel == PIXEL_INSIDE)
               inside_seen++;
            else
               escaped_seen++;
            points_seen++;
            pixels_due.push_back(want);
         end
      end
   end

   // result side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic offer_point(logic [GRID_W-1:0] r, logic [GRID_W-1:0] q,
                              bit typed, logic [PIXEL_W-1:0] px);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      point_typed = typed;
      point_typed_pixel = px;
      req_if.valid <= 1'b1;
      req_if.row <= r;
      req_if.col <= q;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic drain();
      park_sender();
      while (pixels_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] d);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= d;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] xo, yo, xs, ys, jr, ji, lim;
      logic [GRID_W-1:0] r, q;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.row = '0;
      req_if.col = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_MODE;
      csr_if.data = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == DIR_WRITE) begin
            drain();
            write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
         end else begin
            offer_point(DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].typed,
                        DIRECTED[i].pixel);
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         if (ph % 8 == 7) begin
            // noise: anything the registers hold, short budget
            xo = $urandom();
            yo = $urandom();
            xs = $urandom();
            ys = $urandom();
            jr = $urandom();
            ji = $urandom();
            lim = $urandom_range(0, 12);
         end else begin
            xs = {1'($urandom_range(1)), 31'($urandom_range(1 << 15, 1 << 19))};
            ys = {1'($urandom_range(1)), 31'($urandom_range(1 << 15, 1 << 19))};
            xo = -$urandom_range(1 << 25, 5 << 25);
            yo = -$urandom_range(1 << 25, 5 << 25);
            jr = $urandom_range(0, 3 << 25) - (1 << 26);
            ji = $urandom_range(0, 1 << 27) - (1 << 26);
            lim = ($urandom_range(99) < 85) ? $urandom_range(0, 40) : $urandom_range(41, 255);
         end
         write_reg(CSR_MODE, ($urandom() & ~32'h1) | 32'($urandom_range(1)));
         write_reg(CSR_X_ORIGIN, xo);
         write_reg(CSR_Y_ORIGIN, yo);
         write_reg(CSR_X_STEP, xs);
         write_reg(CSR_Y_STEP, ys);
         write_reg(CSR_ITER_LIMIT, {16'($urandom()), lim[ITER_W-1:0]});
         write_reg(CSR_JULIA_RE, jr);
         write_reg(CSR_JULIA_IM, ji);

         case (ph % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin req_idle_pct = 13; rsp_stall_pct = 13; end
         endcase

         for (int k = 0; k < PHASE_PTS; k++) begin
            r = ($urandom_range(99) < 80) ? GRID_W'($urandom_range(0, 1024))
                                          : GRID_W'($urandom_range(0, 2047));
            q = ($urandom_range(99) < 80) ? GRID_W'($urandom_range(0, 1024))
                                          : GRID_W'($urandom_range(0, 2047));
            offer_point(r, q, 1'b0, PIXEL_ESCAPED);
            // back up the result side while points keep coming
            if (ph == 0 && k == 40)
               hold_cycles = 400;
            if (ph == 6 && k == 60) begin
               park_sender();
               while (pixels_due.size() != 0)
                  @(posedge clock);
            end
         end
      end

      park_sender();
      while (pixels_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d pixels (%0d bounded, %0d escaped) across %0d register writes",
               points_seen, inside_seen, escaped_seen, writes_seen);
      $display("Corner points, saturation and both fractal modes, then %0d random settings",
               N_PHASES);
      if (mismatches == 0)
         $display("escape_time_fractal_pixel_unit test passed");
      else
         $display("escape_time_fractal_pixel_unit test failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/efp_pkg.sv
rtl/core/efp_interfaces.sv
rtl/core/efp_csr.sv
rtl/core/efp_datapath.sv
rtl/core/efp_ctrl.sv
rtl/core/escape_time_fractal_pixel_unit.sv
rtl/core/efp_checker.sv
verif/tb_top.sv
